// File: design/lwr_pkg.sv
package lwr_pkg;

   localparam int CHAR_W       = 21;
   localparam int LIMIT_W      = 6;
   localparam int MAX_WORD_DEF = 32;
   localparam int PHRASE_LEN   = 15;
   localparam int PHRASE_IDX_W = 4;
   localparam int CMP_W        = 7;

   localparam logic [LIMIT_W-1:0]      LIMIT_RESET     = 6'd32;
   localparam logic [PHRASE_IDX_W-1:0] PHRASE_LAST_IDX = 4'(PHRASE_LEN - 1);

   localparam logic [CHAR_W-1:0] CH_TAB   = 21'h9;
   localparam logic [CHAR_W-1:0] CH_CR    = 21'hD;
   localparam logic [CHAR_W-1:0] CH_SPACE = 21'h20;
   localparam logic [CHAR_W-1:0] CH_COMMA = 21'h2C;
   localparam logic [CHAR_W-1:0] CH_DOT   = 21'h2E;

   // Replacement phrase "(bolshoe slovo)" in Cyrillic.
   function automatic logic [CHAR_W-1:0] phrase_char(input logic [PHRASE_IDX_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      case (idx)
         4'd0:    c = 21'h28;
         4'd1:    c = 21'h431;
         4'd2:    c = 21'h43E;
         4'd3:    c = 21'h43B;
         4'd4:    c = 21'h44C;
         4'd5:    c = 21'h448;
         4'd6:    c = 21'h43E;
         4'd7:    c = 21'h435;
         4'd8:    c = 21'h20;
         4'd9:    c = 21'h441;
         4'd10:   c = 21'h43B;
         4'd11:   c = 21'h43E;
         4'd12:   c = 21'h432;
         4'd13:   c = 21'h43E;
         4'd14:   c = 21'h29;
         default: c = 21'h29;
      endcase
      return c;
   endfunction

   // ASCII whitespace, '.' and ','.
   function automatic logic is_delim(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR) ||
             (c == CH_DOT) || (c == CH_COMMA);
   endfunction

endpackage

// File: design/lwr_ram.sv
module lwr_ram #(
   parameter int WIDTH  = 21,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/long_word_replacer.sv
// Word filter for a stream of Unicode code points. Each req_ transfer carries one
// character; words (runs of characters other than ASCII whitespace, '.' and ',')
// are collected in a MAX_WORD-entry RAM and, once a delimiter or the sentence-end
// flag closes them, sent out unchanged if they hold at most csr_word_limit
// characters, or replaced by the 15-character phrase "(bolshoe slovo)" in Cyrillic.
// Words longer than MAX_WORD are always replaced. Delimiters follow their word,
// and rsp_sentence_done marks the last character a sentence emits. A word
// character with no sentence end gives no result. A flush of a kept word reads
// the RAM and then loads the output for each character, since the word RAM has
// a registered read port; a replaced word loads the phrase characters in turn,
// and a delimiter is loaded after the word it closes. Input is
// stalled for the whole flush. Results leave through an output register, so a
// stalled rsp_ side only holds the block while a flush is waiting on it. The user
// writes csr_word_limit only while the block is idle; the block does not check it.
module long_word_replacer
   import lwr_pkg::*;
#(
   parameter int MAX_WORD = MAX_WORD_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_write_en,
   input  logic [LIMIT_W-1:0] csr_word_limit,
   // input characters
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CHAR_W-1:0]  req_char_code,
   input  logic               req_end_of_sentence,
   // output characters
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_out_char,
   output logic               rsp_sentence_done
);

   localparam int LEN_W = $clog2(MAX_WORD + 1);
   localparam int IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;  // RAM read issued
   localparam logic [2:0] S_SEND   = 3'd2;  // RAM data ready for the output
   localparam logic [2:0] S_PHRASE = 3'd3;  // phrase characters
   localparam logic [2:0] S_DELIM  = 3'd4;  // delimiter after the word

   logic [2:0]              state_ff, state_in;
   logic [LIMIT_W-1:0]      limit_ff, limit_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic                    too_long_ff, too_long_in;
   logic [LEN_W-1:0]        idx_ff, idx_in;
   logic [PHRASE_IDX_W-1:0] phr_ff, phr_in;
   logic                    pend_delim_ff, pend_delim_in;
   logic                    eos_ff, eos_in;
   logic [CHAR_W-1:0]       delim_ff, delim_in;

   logic                    out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]       out_char_ff, out_char_in;
   logic                    out_done_ff, out_done_in;

   logic                    req_take;
   logic                    out_free;
   logic                    in_delim;
   logic                    have_word;
   logic                    replace;
   logic                    ram_we;
   logic [CHAR_W-1:0]       ram_rdata;
   logic [LEN_W-1:0]        len_upd;
   logic                    too_long_upd;
   logic                    word_last;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   // output register is free when empty or being taken this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_delim  = is_delim(req_char_code);

   // word state as it stands after storing a word character
   assign len_upd      = (len_ff < LEN_MAX) ? len_ff + LEN_W'(1) : len_ff;
   assign too_long_upd = too_long_ff || (len_ff == LEN_MAX);
   assign ram_we       = req_take && !in_delim && (len_ff < LEN_MAX);

   assign have_word = (len_ff != '0) || too_long_ff;
   // flush choice, from the state before a delimiter or after a sentence-end char
   always_comb begin
      if (in_delim) begin
         replace = too_long_ff ||
                   ({{(CMP_W-LEN_W){1'b0}}, len_ff} > {{(CMP_W-LIMIT_W){1'b0}}, limit_ff});
      end else begin
         replace = too_long_upd ||
                   ({{(CMP_W-LEN_W){1'b0}}, len_upd} > {{(CMP_W-LIMIT_W){1'b0}}, limit_ff});
      end
   end

   assign word_last = (idx_ff + LEN_W'(1) == len_ff);

   lwr_ram #(
      .WIDTH  (CHAR_W),
      .DEPTH  (MAX_WORD),
      .ADDR_W (IDX_W)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (len_ff[IDX_W-1:0]),
      .wr_data (req_char_code),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      limit_in      = limit_ff;
      len_in        = len_ff;
      too_long_in   = too_long_ff;
      idx_in        = idx_ff;
      phr_in        = phr_ff;
      pend_delim_in = pend_delim_ff;
      eos_in        = eos_ff;
      delim_in      = delim_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_char_in   = out_char_ff;
      out_done_in   = out_done_ff;

      if (csr_write_en) begin
         limit_in = csr_word_limit;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               eos_in = req_end_of_sentence;
               idx_in = '0;
               phr_in = '0;
               if (in_delim) begin
                  delim_in      = req_char_code;
                  pend_delim_in = 1'b1;
                  if (!have_word) begin
                     state_in = S_DELIM;
                  end else if (replace) begin
                     state_in = S_PHRASE;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  len_in        = len_upd;
                  too_long_in   = too_long_upd;
                  pend_delim_in = 1'b0;
                  if (req_end_of_sentence) begin
                     state_in = replace ? S_PHRASE : S_READ;
                  end
               end
            end
         end
         S_READ: begin
            state_in = S_SEND;
         end
         S_SEND: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = ram_rdata;
               out_done_in  = eos_ff && !pend_delim_ff && word_last;
               if (word_last) begin
                  len_in      = '0;
                  too_long_in = 1'b0;
                  state_in    = pend_delim_ff ? S_DELIM : S_IDLE;
               end else begin
                  idx_in   = idx_ff + LEN_W'(1);
                  state_in = S_READ;
               end
            end
         end
         S_PHRASE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = phrase_char(phr_ff);
               out_done_in  = eos_ff && !pend_delim_ff && (phr_ff == PHRASE_LAST_IDX);
               if (phr_ff == PHRASE_LAST_IDX) begin
                  len_in      = '0;
                  too_long_in = 1'b0;
                  state_in    = pend_delim_ff ? S_DELIM : S_IDLE;
               end else begin
                  phr_in = phr_ff + PHRASE_IDX_W'(1);
               end
            end
         end
         S_DELIM: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = delim_ff;
               out_done_in  = eos_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= LIMIT_RESET;
         len_ff       <= '0;
         too_long_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         len_ff       <= len_in;
         too_long_ff  <= too_long_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff        <= idx_in;
      phr_ff        <= phr_in;
      pend_delim_ff <= pend_delim_in;
      eos_ff        <= eos_in;
      delim_ff      <= delim_in;
      out_char_ff   <= out_char_in;
      out_done_ff   <= out_done_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_char      = out_char_ff;
   assign rsp_sentence_done = out_done_ff;

   // word count never exceeds the RAM depth
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_MAX)
      else $error("word length beyond storage");

   // RAM flush only reads entries of the current word
   a_idx_in_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_SEND) |-> (idx_ff < len_ff))
      else $error("flush index past word end");

   // a finished flush leaves the word empty
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEND && out_free && word_last) |=> (len_ff == '0 && !too_long_ff))
      else $error("word state not cleared after flush");

   // the output register is never overwritten while stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_char_ff)))
      else $error("pending result overwritten");

   // phrase counter stays inside the phrase
   a_phrase_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PHRASE) |-> (phr_ff <= PHRASE_LAST_IDX))
      else $error("phrase index out of range");

endmodule

// File: verif/long_word_replacer_test.sv
`timescale 1ns / 100ps

// Self-checking bench for long_word_replacer.
// Characters go in one per req_ transfer. A local predictor rebuilds each word,
// decides keep or replace, and queues the characters that should come out.
// Every rsp_ transfer is checked in order against that queue.
module long_word_replacer_test;
   import lwr_pkg::*;

   localparam int CHAR_MAX    = (1 << CHAR_W) - 1;
   localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
   localparam int HOLD_OFF    = 80;    // idle wait after draining, to cover a full 32-char flush
   localparam int TAIL_CYCLES = 100;

   localparam logic [CHAR_W-1:0] CH_LOWER_A  = 21'h61;
   localparam logic [CHAR_W-1:0] CH_CYR_BASE = 21'h400;
   localparam logic [CHAR_W-1:0] CH_UNI_TOP  = 21'h10FFFF;

   // Replacement text for an over-long word, in emit order.
   localparam logic [0:PHRASE_LEN-1][CHAR_W-1:0] BIG_WORD_TEXT = {
      21'h28,  21'h431, 21'h43E, 21'h43B, 21'h44C, 21'h448, 21'h43E, 21'h435,
      21'h20,  21'h441, 21'h43B, 21'h43E, 21'h432, 21'h43E, 21'h29
   };

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              done;
   } emitted_char_type;

   // DUT signals. Every input starts at a known value.
   logic               clock               = 1'b0;
   logic               reset               = 1'b1;
   logic               csr_write_en        = 1'b0;
   logic [LIMIT_W-1:0] csr_word_limit      = '0;
   logic               req_valid           = 1'b0;
   logic               req_stall;
   logic [CHAR_W-1:0]  req_char_code       = '0;
   logic               req_end_of_sentence = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall           = 1'b0;
   logic [CHAR_W-1:0]  rsp_out_char;
   logic               rsp_sentence_done;

   // Predictor state: the word being collected and the current limit.
   logic [CHAR_W-1:0]  word_chars [MAX_WORD_DEF];
   int                 word_len      = 0;
   bit                 word_overflow = 1'b0;
   logic [LIMIT_W-1:0] limit_setting = LIMIT_RESET;

   emitted_char_type expected_chars[$];
   emitted_char_type oldest_char;

   int  mismatch_count = 0;
   int  items_sent     = 0;
   int  idle_cycles    = 0;
   bit  steady         = 1'b0;  // set for the last phase: no gaps, no stalls

   long_word_replacer u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_word_limit      (csr_word_limit),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_char_code       (req_char_code),
      .req_end_of_sentence (req_end_of_sentence),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_char        (rsp_out_char),
      .rsp_sentence_done   (rsp_sentence_done)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Whitespace 9..13 and 32, plus '.' and ','.
   function automatic bit is_separator(input logic [CHAR_W-1:0] c);
      return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE ||
             c == CH_DOT || c == CH_COMMA;
   endfunction

   // Push the pending word (kept or replaced). done marks its last char.
   task automatic emit_word(input bit done);
      if (word_len == 0 && !word_overflow)
         return;
      if (word_overflow || word_len > limit_setting) begin
         for (int i = 0; i < PHRASE_LEN; i++)
            expected_chars.push_back('{BIG_WORD_TEXT[i], done && i == PHRASE_LEN - 1});
      end else begin
         for (int i = 0; i < word_len; i++)
            expected_chars.push_back('{word_chars[i], done && i == word_len - 1});
      end
      word_len      = 0;
      word_overflow = 1'b0;
   endtask

   task automatic rewrite_char(input logic [CHAR_W-1:0] code, input logic eos);
      if (is_separator(code)) begin
         // separator follows the word it closes and takes the sentence mark
         emit_word(1'b0);
         expected_chars.push_back('{code, eos});
         return;
      end
      if (word_len < MAX_WORD_DEF) begin
         word_chars[word_len] = code;
         word_len++;
      end else begin
         word_overflow = 1'b1;  // past storage: replaced whatever the limit
      end
      if (eos)
         emit_word(1'b1);
   endtask

   // ------------------------------------------------------------------
   // Result checker: compare each rsp_ transfer with the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected out_char %h sentence_done %b", rsp_out_char,
                   rsp_sentence_done);
            mismatch_count++;
         end else begin
            oldest_char = expected_chars.pop_front();
            if (rsp_out_char !== oldest_char.code) begin
               $error("out_char: expected %h, got %h", oldest_char.code, rsp_out_char);
               mismatch_count++;
            end
            if (rsp_sentence_done !== oldest_char.done) begin
               $error("sentence_done: expected %b, got %b", oldest_char.done,
                      rsp_sentence_done);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: any transfer on either side resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Output backpressure: random stall bursts of random length.
   initial begin : rsp_backpressure
      int left;
      left = 0;
      forever begin
         @(negedge clock);
         if (steady) begin
            left = 0;
            rsp_stall <= 1'b0;
         end else if (left > 0) begin
            left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 11) == 0) begin
            left = $urandom_range(0, 16);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // One req_ transfer, with an occasional random gap in front.
   // Valid stays high from one transfer to the next unless a gap is taken.
   task automatic send_char(input logic [CHAR_W-1:0] code, input logic eos);
      int gap;
      @(negedge clock);
      if (!steady && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_char_code       <= code;
      req_end_of_sentence <= eos;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      rewrite_char(code, eos);
      items_sent++;
   endtask

   // Stop sending and wait until every expected char has come out, then
   // give the block time to finish any internal work.
   task automatic drain_outputs();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0)
         @(negedge clock);
      repeat (HOLD_OFF) @(negedge clock);
   endtask

   task automatic set_word_limit(input logic [LIMIT_W-1:0] value);
      drain_outputs();
      csr_write_en   <= 1'b1;
      csr_word_limit <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      limit_setting = value;
   endtask

   function automatic logic [CHAR_W-1:0] random_word_char();
      logic [CHAR_W-1:0] c;
      case ($urandom_range(0, 3))
         0:       c = CHAR_W'($urandom_range(0, CHAR_MAX));
         1:       c = CH_LOWER_A + CHAR_W'($urandom_range(0, 25));
         2:       c = CH_CYR_BASE + CHAR_W'($urandom_range(0, 255));
         default: c = CHAR_W'($urandom_range(CH_UNI_TOP, CHAR_MAX));
      endcase
      if (is_separator(c))
         c = CH_LOWER_A;
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] random_delim();
      case ($urandom_range(0, 3))
         0:       return CH_SPACE;
         1:       return CH_DOT;
         2:       return CH_COMMA;
         default: return CH_TAB + CHAR_W'($urandom_range(0, 4));
      endcase
   endfunction

   // Mostly short words, some medium, a few around and past the 32-entry store.
   function automatic int random_word_len();
      int r;
      r = $urandom_range(0, 19);
      if (r < 13)
         return $urandom_range(1, 6);
      else if (r < 17)
         return $urandom_range(7, 16);
      else
         return $urandom_range(28, 40);
   endfunction

   // A well-formed sentence with random words; sometimes a stray char in front.
   task automatic send_sentence();
      int n_words;
      int len;
      bit end_on_word;
      n_words     = $urandom_range(1, 4);
      end_on_word = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 6) == 0)
         send_char(CHAR_W'($urandom_range(0, CHAR_MAX)), 1'($urandom_range(0, 1)));
      for (int w = 0; w < n_words; w++) begin
         len = random_word_len();
         for (int i = 0; i < len; i++)
            send_char(random_word_char(), end_on_word && w == n_words - 1 && i == len - 1);
         if (w < n_words - 1)
            repeat ($urandom_range(1, 2)) send_char(random_delim(), 1'b0);
      end
      // sentence closed by a separator unless the last word carried the mark
      if (!end_on_word)
         send_char(random_delim(), 1'b1);
   endtask

   task automatic send_sentences(input int n_items);
      int first;
      first = items_sent;
      while (items_sent - first < n_items)
         send_sentence();
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset limit of 32: field extremes, every separator, sentence ends on
   // a word char and on a separator, a separator-only sentence.
   task automatic test_reset_limit();
      send_char('0, 1'b0);
      send_char(CHAR_W'(CHAR_MAX), 1'b0);  // above the Unicode range: word char
      send_char(CH_SPACE, 1'b0);
      send_char(CH_UNI_TOP, 1'b1);      // one-char word ends the sentence
      for (int c = CH_TAB; c <= CH_CR; c++)
         send_char(CHAR_W'(c), 1'b0);
      send_char(CH_DOT, 1'b1);          // sentence of separators only
      send_char(CH_LOWER_A, 1'b0);
      send_char(CH_LOWER_A + CHAR_W'(1), 1'b0);
      send_char(CH_DOT, 1'b1);          // word flushed, then dot carries the mark
      send_char(CH_COMMA, 1'b0);
   endtask

   // Limit 0: every word is replaced.
   task automatic test_zero_limit();
      set_word_limit('0);
      send_char(CH_LOWER_A, 1'b0);
      send_char(CH_COMMA, 1'b0);
      send_char(CH_LOWER_A + CHAR_W'(2), 1'b0);
      send_char(CH_CYR_BASE, 1'b1);     // phrase with the mark on its last char
      send_char(CH_SPACE, 1'b1);
   endtask

   // Limit above the store: only words past 32 chars get replaced.
   task automatic test_limit_above_store();
      set_word_limit({LIMIT_W{1'b1}});
      send_sentences(20);
   endtask

   task automatic test_limit_one();
      set_word_limit(6'd1);
      send_sentences(15);
   endtask

   task automatic test_random_limit();
      set_word_limit(LIMIT_W'($urandom_range(2, 31)));
      send_sentences(20);
   endtask

   // Last phase: back-to-back on both sides.
   task automatic test_full_rate();
      set_word_limit(LIMIT_W'($urandom_range(3, 8)));
      steady = 1'b1;
      send_sentences(30);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_limit();
      test_zero_limit();
      test_limit_above_store();
      test_limit_one();
      test_random_limit();
      test_full_rate();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
